// ===== sv/lfu_cache_table_macros.svh =====
// Assertion macros for the cache table checker.
// Used by the checker file only.
`ifndef LFU_CACHE_TABLE_MACROS_SVH
`define LFU_CACHE_TABLE_MACROS_SVH
// Implication checked on every clock unless reset is low.
`define LFU_ASSERT_IMP(label, clk, rstn, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define LFU_ASSERT_NXT(label, clk, rstn, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`endif

// ===== sv/lfu_pkg.sv =====
// Shared types and constants of the cache table.
// No dependencies.
package lfu_pkg;
  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [15:0] CountMax = 16'hFFFF;
  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic commit;
  } lfu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } lfu_sts_t;
endpackage

// ===== sv/lfu_ctrl.sv =====
// Controller of the cache table: sequences load, scan and commit.
// Depends on lfu_pkg.
module lfu_ctrl import lfu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     strobe,
  output lfu_cmd_t cmd_o,
  input  lfu_sts_t sts_i
);
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StDone = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = StDone;
      end
      StDone: begin
        cmd_o.commit = 1'b1;
        state_d      = StOut;
      end
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  assign busy   = (state_q != StIdle);
  assign strobe = (state_q == StOut);
endmodule

// ===== sv/lfu_dpath.sv =====
// Datapath of the cache table: entry storage, scan unit and result registers.
// Depends on lfu_pkg.
module lfu_dpath import lfu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lfu_cmd_t    cmd_i,
  output lfu_sts_t    sts_o,
  input  logic        opcode_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  input  logic [4:0]  cap_i,
  output logic        hit_o,
  output logic [31:0] read_value_o,
  output logic        evicted_o,
  output logic [31:0] evicted_key_o
);
  logic [Depth-1:0] valid_q;
  logic [31:0] key_q [Depth];
  logic [31:0] val_q [Depth];
  logic [15:0] cnt_q [Depth];
  logic [39:0] stamp_q [Depth];
  logic [39:0] stamp_ctr_q;

  logic        op_q;
  logic [31:0] ikey_q, ival_q;
  logic [IdxW-1:0] idx_q;
  logic        hit_q, hfree_q, have_q;
  logic [IdxW-1:0] found_q, free_q, vic_q;
  logic [CntW-1:0] used_q;
  logic [15:0] vcnt_q;
  logic [39:0] vstamp_q;
  logic [31:0] vkey_q;

  assign sts_o.scan_last = (idx_q == IdxW'(Depth - 1));

  // Capacity clipped to the table depth.
  logic [CntW-1:0] cap_eff;
  assign cap_eff = (32'(cap_i) > Depth) ? CntW'(Depth) : CntW'(cap_i);

  // Scan state, one entry per cycle.
  logic cur_better;
  always_comb begin
    cur_better = !have_q || (cnt_q[idx_q] < vcnt_q) ||
                 ((cnt_q[idx_q] == vcnt_q) && (stamp_q[idx_q] < vstamp_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; hit_q <= 1'b0; hfree_q <= 1'b0; have_q <= 1'b0; used_q <= '0;
    end else if (cmd_i.scan_clr) begin
      idx_q <= '0; hit_q <= 1'b0; hfree_q <= 1'b0; have_q <= 1'b0; used_q <= '0;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + 1'b1;
      if (valid_q[idx_q]) begin
        used_q <= used_q + 1'b1;
        if (!hit_q && key_q[idx_q] == ikey_q) begin
          hit_q <= 1'b1;
          found_q <= idx_q;
        end
        if (cur_better) begin
          have_q <= 1'b1;
          vic_q <= idx_q;
          vcnt_q <= cnt_q[idx_q];
          vstamp_q <= stamp_q[idx_q];
          vkey_q <= key_q[idx_q];
        end
      end else if (!hfree_q) begin
        hfree_q <= 1'b1;
        free_q <= idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i; ikey_q <= key_i; ival_q <= value_i;
    end
  end

  // Commit: decide the action and produce the result.
  logic need_evict;
  assign need_evict = (used_q >= cap_eff) || !hfree_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      stamp_ctr_q <= '0;
    end else if (cmd_i.commit) begin
      if (hit_q && (op_q == OpGet || cap_eff != '0)) begin
        stamp_ctr_q <= stamp_ctr_q + 40'd1;
      end else if (op_q == OpPut && cap_eff != '0 && !hit_q &&
                   (!need_evict || have_q)) begin
        valid_q[need_evict ? vic_q : free_q] <= 1'b1;
        stamp_ctr_q <= stamp_ctr_q + 40'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_o <= hit_q;
      read_value_o <= '0;
      evicted_o <= 1'b0;
      evicted_key_o <= '0;
      if (op_q == OpGet) begin
        if (hit_q) begin
          read_value_o <= val_q[found_q];
          if (cnt_q[found_q] < CountMax) cnt_q[found_q] <= cnt_q[found_q] + 16'd1;
          stamp_q[found_q] <= stamp_ctr_q;
        end else begin
          read_value_o <= '1;
        end
      end else if (cap_eff != '0) begin
        if (hit_q) begin
          val_q[found_q] <= ival_q;
          if (cnt_q[found_q] < CountMax) cnt_q[found_q] <= cnt_q[found_q] + 16'd1;
          stamp_q[found_q] <= stamp_ctr_q;
        end else if (!need_evict || have_q) begin
          if (need_evict) begin
            evicted_o <= 1'b1;
            evicted_key_o <= vkey_q;
          end
          key_q[need_evict ? vic_q : free_q] <= ikey_q;
          val_q[need_evict ? vic_q : free_q] <= ival_q;
          cnt_q[need_evict ? vic_q : free_q] <= 16'd1;
          stamp_q[need_evict ? vic_q : free_q] <= stamp_ctr_q;
        end
      end
    end
  end
endmodule

// ===== sv/lfu_cache_table.sv =====
// LFU cache table with LRU tie-break over 16 entries. The start edge loads the item; the
// controller then runs a scan that visits one entry per cycle for both the key match and
// the victim search, then a commit state and a result state with the result strobe high.
// Busy drops at the edge that ends the result state; a new item is accepted only while
// busy is low, so none is taken before the last is through. The result strobe lasts one
// cycle and cannot be held off; capture it when it appears. Capacity must be written
// through the cfg channel only while busy is low; the block itself does not enforce this.
module lfu_cache_table import lfu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        strobe,
  output logic        hit_o,
  output logic [31:0] read_value_o,
  output logic        evicted_o,
  output logic [31:0] evicted_key_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data_i
);
  lfu_cmd_t cmd;
  lfu_sts_t sts;
  logic [4:0] cap_q;

  // Capacity register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= 5'd16;
    else if (cfg_valid && cfg_ready) cap_q <= cfg_data_i;
  end

  lfu_ctrl u_ctrl (.clk_i, .rst_ni, .start(start && !busy), .busy, .strobe,
                   .cmd_o(cmd), .sts_i(sts));

  lfu_dpath u_dpath (.clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .opcode_i,
                     .key_i, .value_i, .cap_i(cap_q), .hit_o, .read_value_o,
                     .evicted_o, .evicted_key_o);
endmodule

// ===== sv/lfu_checker.sv =====
// Port checker for the cache table, bound to the top level.
// Depends on lfu_cache_table_macros.svh.
`include "lfu_cache_table_macros.svh"
module lfu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic        evicted_o,
  input logic        hit_o,
  input logic [31:0] evicted_key_o
);
  // An accepted item makes the block busy.
  `LFU_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy, "no busy after start")
  // A result is shown only while busy.
  `LFU_ASSERT_IMP(a_strobe_busy, clk_i, rst_ni, strobe, busy, "strobe while idle")
  // The strobe lasts one cycle and frees the block.
  `LFU_ASSERT_NXT(a_strobe_one, clk_i, rst_ni, strobe, !strobe && !busy, "strobe too long")
  // An eviction never comes with a hit.
  `LFU_ASSERT_IMP(a_evict_hit, clk_i, rst_ni, strobe && evicted_o, !hit_o, "evict on hit")
  // Without an eviction the evicted key reads as zero.
  `LFU_ASSERT_IMP(a_evict_key, clk_i, rst_ni, strobe && !evicted_o, evicted_key_o == '0, "stray key")
endmodule

bind lfu_cache_table lfu_checker u_chk (.clk_i, .rst_ni, .start, .busy, .strobe,
  .evicted_o, .hit_o, .evicted_key_o);

// ===== bench/lfu_cache_table_test.sv =====
// Self-checking bench for the LFU cache table with LRU tie-break.
// Depends on lfu_pkg and the lfu_cache_table top level only.
`timescale 1ns / 100ps

module lfu_cache_table_test;
  import lfu_pkg::*;

  localparam int Slots = 16;

  typedef struct {
    logic        op;
    logic [31:0] key;
    logic [31:0] value;
  } cache_req_t;

  typedef struct {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } cache_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        opcode_i = OpGet;
  logic [31:0] key_i = '0;
  logic [31:0] value_i = '0;
  logic        strobe;
  logic        hit_o;
  logic [31:0] read_value_o;
  logic        evicted_o;
  logic [31:0] evicted_key_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data_i = '0;

  lfu_cache_table dut (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .key_i, .value_i,
    .strobe, .hit_o, .read_value_o, .evicted_o, .evicted_key_o,
    .cfg_valid, .cfg_ready, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the cache contents.
  logic [4:0]  shadow_cap;
  logic        shadow_valid [Slots];
  logic [31:0] shadow_key [Slots];
  logic [31:0] shadow_value [Slots];
  logic [15:0] shadow_count [Slots];
  logic [39:0] shadow_stamp [Slots];
  logic [39:0] shadow_clock;

  cache_req_t pending_reqs[$];
  cache_rsp_t expected_rsps[$];
  int errors = 0;
  int accepted = 0;
  int rsp_seen = 0;
  int evictions_seen = 0;
  int hits_seen = 0;
  bit stim_done = 1'b0;
  logic [31:0] key_pool [8];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
    errors++;
  endtask

  function automatic void mark_use(input int i, input bit bump_count);
    if (bump_count && shadow_count[i] != CountMax) shadow_count[i]++;
    shadow_stamp[i] = shadow_clock;
    shadow_clock++;
  endfunction

  // Applies one item to the shadow cache and returns the expected result.
  function automatic cache_rsp_t apply_lookup(input cache_req_t rq);
    cache_rsp_t r;
    int found, used, free_slot, victim, limit;
    bit hit, have_free, have_victim;
    found = 0; used = 0; free_slot = 0; victim = 0;
    hit = 0; have_free = 0; have_victim = 0;
    limit = (shadow_cap > Slots) ? Slots : shadow_cap;
    for (int i = 0; i < Slots; i++) begin
      if (shadow_valid[i]) begin
        used++;
        if (!hit && shadow_key[i] == rq.key) begin
          hit = 1; found = i;
        end
      end else if (!have_free) begin
        have_free = 1; free_slot = i;
      end
    end
    r.hit = hit; r.read_value = '0; r.evicted = 0; r.evicted_key = '0;
    if (rq.op == OpGet) begin
      if (hit) begin
        r.read_value = shadow_value[found];
        mark_use(found, 1);
      end else begin
        r.read_value = 32'hFFFF_FFFF;
      end
      return r;
    end
    if (limit == 0) return r;
    if (hit) begin
      shadow_value[found] = rq.value;
      mark_use(found, 1);
      return r;
    end
    if (used >= limit || !have_free) begin
      for (int i = 0; i < Slots; i++) begin
        if (shadow_valid[i] && (!have_victim || shadow_count[i] < shadow_count[victim] ||
            (shadow_count[i] == shadow_count[victim] &&
             shadow_stamp[i] < shadow_stamp[victim]))) begin
          victim = i; have_victim = 1;
        end
      end
      if (!have_victim) return r;
      r.evicted = 1; r.evicted_key = shadow_key[victim];
      free_slot = victim;
    end
    shadow_valid[free_slot] = 1;
    shadow_key[free_slot] = rq.key;
    shadow_value[free_slot] = rq.value;
    shadow_count[free_slot] = 1;
    mark_use(free_slot, 0);
    return r;
  endfunction

  // Busy as seen just before the last rising edge.
  logic busy_at_edge = 1'b1;

  // Driver: issues queued items with random gaps.
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy_at_edge) begin
        start <= 1'b0;
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) :
                    (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
      end else if (!start && pending_reqs.size() > 0) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else begin
          opcode_i <= pending_reqs[0].op;
          key_i <= pending_reqs[0].key;
          value_i <= pending_reqs[0].value;
          start <= 1'b1;
        end
      end
    end
  end

  // Acceptance is decided at the rising edge.
  always @(posedge clk_i) begin
    busy_at_edge <= busy;
    if (rst_ni && start && !busy) begin
      expected_rsps.push_back(apply_lookup(pending_reqs.pop_front()));
      accepted++;
    end
  end

  // Monitor: checks each strobed result against the oldest expectation.
  always @(posedge clk_i) begin
    cache_rsp_t want;
    if (rst_ni && strobe) begin
      rsp_seen++;
      if (expected_rsps.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        want = expected_rsps.pop_front();
        if (want.hit) hits_seen++;
        if (want.evicted) evictions_seen++;
        if (hit_o !== want.hit) report("hit", 32'(hit_o), 32'(want.hit));
        if (read_value_o !== want.read_value) report("read_value", read_value_o, want.read_value);
        if (evicted_o !== want.evicted)
          report("evicted", 32'(evicted_o), 32'(want.evicted));
        if (evicted_key_o !== want.evicted_key)
          report("evicted_key", evicted_key_o, want.evicted_key);
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    @(negedge clk_i);
    cfg_data_i <= cap;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    shadow_cap = cap;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_req(input logic op, input logic [31:0] k, input logic [31:0] v);
    cache_req_t rq;
    rq.op = op; rq.key = k; rq.value = v;
    pending_reqs.push_back(rq);
  endfunction

  // Random phase mostly reuses a small key set so hits and evictions are common.
  task automatic random_phase(input int count);
    logic [31:0] k;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, 7)] + $urandom_range(0, 3);
      else k = $urandom();
      add_req(1'($urandom_range(0, 1)), k, $urandom());
    end
    wait_drained();
  endtask

  initial begin
    logic [4:0] caps [6];
    caps = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8};
    shadow_cap = 5'd16;
    shadow_clock = '0;
    for (int i = 0; i < Slots; i++) begin
      shadow_valid[i] = 0; shadow_key[i] = '0; shadow_value[i] = '0;
      shadow_count[i] = '0; shadow_stamp[i] = '0;
    end
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h0; key_pool[1] = 32'hFFFF_FFFC;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: misses, extreme values, fill to capacity, tie-break evictions.
    add_req(OpGet, 32'h0, 32'h0);
    add_req(OpPut, 32'h0, 32'h8000_0000);
    add_req(OpPut, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    add_req(OpGet, 32'h0, 32'h0);
    add_req(OpGet, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(OpPut, 32'h0, 32'hFFFF_FFFF);
    for (int i = 2; i < 18; i++) add_req(OpPut, 32'h100 + i, i);
    add_req(OpGet, 32'h103, 32'h0);
    wait_drained();

    // Capacity zero still serves gets; lowered capacity forces evictions.
    write_capacity(5'd0);
    add_req(OpPut, 32'h103, 32'h5);
    add_req(OpPut, 32'h999, 32'h5);
    add_req(OpGet, 32'h103, 32'h0);
    wait_drained();
    write_capacity(5'd2);
    add_req(OpPut, 32'h777, 32'h1);
    add_req(OpPut, 32'h778, 32'h2);
    wait_drained();

    foreach (caps[c]) begin
      write_capacity(caps[c]);
      random_phase(190);
    end
    write_capacity(5'd16);
    random_phase(40);
    stim_done = 1'b1;

    $display("covered %0d items, %0d results: %0d hits, %0d evictions",
             accepted, rsp_seen, hits_seen, evictions_seen);
    $display("capacity settings included 0, 1, 2, 3, 8, 16, 17 and 31");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", expected_rsps.size());
    $display("status: fail");
    $finish;
  end
endmodule
